/* hdl/pixel_color_format_converter_assert.svh */
// Assertion macros for the pixel format converter.
// Each expects clk and rst_n in the scope where it is used.
`ifndef PIXEL_COLOR_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_COLOR_FORMAT_CONVERTER_ASSERT_SVH

`ifndef SYNTH
`define PCFC_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("pixel converter assertion failed");
`define PCFC_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("pixel converter assertion failed");
`else
`define PCFC_ASSERT_IMP(label, lhs, rhs)
`define PCFC_ASSERT_NXT(label, lhs, rhs)
`endif

`endif

/* hdl/pcfc_pkg.sv */
`timescale 1ns / 1ps
package pcfc_pkg;

  typedef logic [15:0] comp_t;

  typedef enum logic [2:0] {
    FMT_RGB   = 3'd0,
    FMT_RGBA  = 3'd1,
    FMT_BGR   = 3'd2,
    FMT_BGRA  = 3'd3,
    FMT_GRAY  = 3'd4,
    FMT_GRAYA = 3'd5
  } fmt_t;

  typedef enum logic [1:0] {
    REG_SRC_FMT  = 2'd0,
    REG_DST_FMT  = 2'd1,
    REG_SRC_WIDE = 2'd2,
    REG_DST_WIDE = 2'd3
  } reg_idx_t;

  // BT.601 luma weights in Q16
  localparam logic [15:0] WEIGHT_R = 16'd19595;
  localparam logic [15:0] WEIGHT_G = 16'd38469;
  localparam logic [15:0] WEIGHT_B = 16'd7471;

  typedef struct packed {
    comp_t comp_a;
    comp_t comp_b;
    comp_t comp_c;
    comp_t comp_d;
  } in_pix_t;

  typedef struct packed {
    comp_t      out_a;
    comp_t      out_b;
    comp_t      out_c;
    comp_t      out_d;
    logic [2:0] out_count;
  } out_pix_t;

  typedef struct packed {
    logic [2:0] src_fmt;
    logic [2:0] dst_fmt;
    logic       src_wide;
    logic       dst_wide;
  } cfg_t;

  typedef struct packed {
    comp_t       r;
    comp_t       g;
    comp_t       b;
    comp_t       alpha;
    comp_t       gray;
    logic        src_gray;
    logic [31:0] prod_r;
    logic [31:0] prod_g;
    logic [31:0] prod_b;
  } chan_t;

  // Undefined layout codes fall back to RGB
  function automatic fmt_t fix_fmt(logic [2:0] code);
    fmt_t f;
    case (code)
      FMT_RGBA:  f = FMT_RGBA;
      FMT_BGR:   f = FMT_BGR;
      FMT_BGRA:  f = FMT_BGRA;
      FMT_GRAY:  f = FMT_GRAY;
      FMT_GRAYA: f = FMT_GRAYA;
      default:   f = FMT_RGB;
    endcase
    return f;
  endfunction

  // Keep all 16 bits when wide, else only the low byte
  function automatic comp_t fit_comp(comp_t v, logic wide);
    return wide ? v : {8'h00, v[7:0]};
  endfunction

endpackage

/* hdl/pcfc_unpack.sv */
`timescale 1ns / 1ps
module pcfc_unpack import pcfc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    pix_valid,
  input  in_pix_t pix,
  input  cfg_t    cfg,
  output logic    chan_valid,
  output chan_t   chan
);

  logic  chan_valid_r;
  chan_t chan_r;
  chan_t chan_nxt;
  comp_t c0, c1, c2, c3;

  always_comb begin
    c0 = fit_comp(pix.comp_a, cfg.src_wide);
    c1 = fit_comp(pix.comp_b, cfg.src_wide);
    c2 = fit_comp(pix.comp_c, cfg.src_wide);
    c3 = fit_comp(pix.comp_d, cfg.src_wide);

    chan_nxt = '0;
    case (fix_fmt(cfg.src_fmt))
      FMT_RGBA: begin
        chan_nxt.r = c0; chan_nxt.g = c1; chan_nxt.b = c2; chan_nxt.alpha = c3;
      end
      FMT_BGR: begin
        chan_nxt.b = c0; chan_nxt.g = c1; chan_nxt.r = c2;
      end
      FMT_BGRA: begin
        chan_nxt.b = c0; chan_nxt.g = c1; chan_nxt.r = c2; chan_nxt.alpha = c3;
      end
      FMT_GRAY: begin
        chan_nxt.src_gray = 1'b1; chan_nxt.gray = c0;
      end
      FMT_GRAYA: begin
        chan_nxt.src_gray = 1'b1; chan_nxt.gray = c0; chan_nxt.alpha = c1;
      end
      default: begin
        chan_nxt.r = c0; chan_nxt.g = c1; chan_nxt.b = c2;
      end
    endcase

    // Gray source fans out into every color channel
    if (chan_nxt.src_gray) begin
      chan_nxt.r = chan_nxt.gray;
      chan_nxt.g = chan_nxt.gray;
      chan_nxt.b = chan_nxt.gray;
    end

    chan_nxt.prod_r = 32'(WEIGHT_R) * 32'(chan_nxt.r);
    chan_nxt.prod_g = 32'(WEIGHT_G) * 32'(chan_nxt.g);
    chan_nxt.prod_b = 32'(WEIGHT_B) * 32'(chan_nxt.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_valid_r <= 1'b0;
    end else begin
      chan_valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
  end

  assign chan_valid = chan_valid_r;
  assign chan       = chan_r;

endmodule

/* hdl/pcfc_pack.sv */
`timescale 1ns / 1ps
module pcfc_pack import pcfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     chan_valid,
  input  chan_t    chan,
  input  cfg_t     cfg,
  output logic     out_valid,
  output out_pix_t out_pix
);

  logic        out_valid_r;
  out_pix_t    out_pix_r;
  out_pix_t    out_pix_nxt;
  logic [33:0] luma_sum;
  comp_t       gray;
  comp_t       res0, res1, res2, res3;

  always_comb begin
    luma_sum = 34'(chan.prod_r) + 34'(chan.prod_g) + 34'(chan.prod_b);
    gray     = chan.src_gray ? chan.gray : luma_sum[31:16];

    res0 = '0;
    res1 = '0;
    res2 = '0;
    res3 = '0;
    out_pix_nxt.out_count = 3'd3;
    case (fix_fmt(cfg.dst_fmt))
      FMT_RGBA: begin
        res0 = chan.r; res1 = chan.g; res2 = chan.b; res3 = chan.alpha;
        out_pix_nxt.out_count = 3'd4;
      end
      FMT_BGR: begin
        res0 = chan.b; res1 = chan.g; res2 = chan.r;
        out_pix_nxt.out_count = 3'd3;
      end
      FMT_BGRA: begin
        res0 = chan.b; res1 = chan.g; res2 = chan.r; res3 = chan.alpha;
        out_pix_nxt.out_count = 3'd4;
      end
      FMT_GRAY: begin
        res0 = gray;
        out_pix_nxt.out_count = 3'd1;
      end
      FMT_GRAYA: begin
        res0 = gray; res1 = chan.alpha;
        out_pix_nxt.out_count = 3'd2;
      end
      default: begin
        res0 = chan.r; res1 = chan.g; res2 = chan.b;
        out_pix_nxt.out_count = 3'd3;
      end
    endcase

    out_pix_nxt.out_a = fit_comp(res0, cfg.dst_wide);
    out_pix_nxt.out_b = fit_comp(res1, cfg.dst_wide);
    out_pix_nxt.out_c = fit_comp(res2, cfg.dst_wide);
    out_pix_nxt.out_d = fit_comp(res3, cfg.dst_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chan_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

endmodule

/* hdl/pixel_color_format_converter.sv */
`timescale 1ns / 1ps
// The start transfer reaches the out_valid strobe through the input register,
// the luma product register and the output register.
// Throughput: one pixel per cycle; busy stays low, results are never stalled.
// Reset (rst_n, synchronous): clears all layout registers to RGB/8-bit and
// drops every pixel in flight.
module pixel_color_format_converter import pcfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_pix_t    in_pix,
  output logic       out_valid,
  output out_pix_t   out_pix,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  cfg_t    cfg_r;
  logic    in_valid_r;
  in_pix_t in_pix_r;
  logic    chan_valid;
  chan_t   chan;
  logic    accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SRC_FMT:  cfg_r.src_fmt  <= cfg_data;
        REG_DST_FMT:  cfg_r.dst_fmt  <= cfg_data;
        REG_SRC_WIDE: cfg_r.src_wide <= cfg_data[0];
        REG_DST_WIDE: cfg_r.dst_wide <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_pix_r <= in_pix;
    end
  end

  pcfc_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (in_valid_r),
    .pix        (in_pix_r),
    .cfg        (cfg_r),
    .chan_valid (chan_valid),
    .chan       (chan)
  );

  pcfc_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .chan_valid (chan_valid),
    .chan       (chan),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_pix    (out_pix)
  );

`include "pixel_color_format_converter_assert.svh"

  `PCFC_ASSERT_IMP(a_count_range, out_valid, out_pix.out_count >= 3'd1 && out_pix.out_count <= 3'd4)
  `PCFC_ASSERT_IMP(a_no_spurious, out_valid, $past(start && !busy, 3))
  `PCFC_ASSERT_IMP(a_no_drop, rst_n && start && !busy ##1 rst_n ##1 rst_n ##1 rst_n, out_valid)
  `PCFC_ASSERT_NXT(a_gray_count, out_valid && out_pix.out_count == 3'd1, !chan_valid || out_valid || cfg_r.dst_fmt == FMT_GRAY)

endmodule

/* dv/pcfc_checker.sv */
`timescale 1ns / 1ps
module pcfc_checker import pcfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_pix_t    in_pix,
  input  logic       out_valid,
  input  out_pix_t   out_pix,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data,
  input  logic       drained,
  output int         n_results,
  output int         n_fail
);

  logic [2:0] src_code;
  logic [2:0] dst_code;
  logic       src_wide;
  logic       dst_wide;
  logic       leftover_checked;
  out_pix_t   pixel_q[$];

  initial begin
    n_results = 0;
    n_fail = 0;
  end

  task automatic report_error(input string msg);
    $display("[%0t] pixel mismatch: %s", $realtime, msg);
    n_fail++;
  endtask

  task automatic compare_comp(input string field, input comp_t got, input comp_t want);
    if (got !== want)
      report_error($sformatf("%s got %h expected %h", field, got, want));
  endtask

  function automatic out_pix_t predict_pixel(input in_pix_t p);
    comp_t       keep;
    comp_t       c0, c1, c2, c3;
    comp_t       r, g, b, alpha, luma;
    logic        gray_src;
    logic [33:0] acc;
    out_pix_t    o;
    keep = src_wide ? 16'hffff : 16'h00ff;
    c0 = p.comp_a & keep;
    c1 = p.comp_b & keep;
    c2 = p.comp_c & keep;
    c3 = p.comp_d & keep;
    r = '0;
    g = '0;
    b = '0;
    alpha = '0;
    luma = '0;
    gray_src = 1'b0;
    case (src_code)
      FMT_RGBA: begin
        r = c0; g = c1; b = c2; alpha = c3;
      end
      FMT_BGR: begin
        b = c0; g = c1; r = c2;
      end
      FMT_BGRA: begin
        b = c0; g = c1; r = c2; alpha = c3;
      end
      FMT_GRAY: begin
        gray_src = 1'b1; luma = c0;
      end
      FMT_GRAYA: begin
        gray_src = 1'b1; luma = c0; alpha = c1;
      end
      // undefined codes decode as RGB
      default: begin
        r = c0; g = c1; b = c2;
      end
    endcase
    if (gray_src) begin
      r = luma;
      g = luma;
      b = luma;
    end else begin
      acc = 34'(WEIGHT_R) * 34'(r) + 34'(WEIGHT_G) * 34'(g) + 34'(WEIGHT_B) * 34'(b);
      luma = acc[31:16];
    end
    o = '0;
    case (dst_code)
      FMT_RGBA: begin
        o.out_a = r; o.out_b = g; o.out_c = b; o.out_d = alpha; o.out_count = 3'd4;
      end
      FMT_BGR: begin
        o.out_a = b; o.out_b = g; o.out_c = r; o.out_count = 3'd3;
      end
      FMT_BGRA: begin
        o.out_a = b; o.out_b = g; o.out_c = r; o.out_d = alpha; o.out_count = 3'd4;
      end
      FMT_GRAY: begin
        o.out_a = luma; o.out_count = 3'd1;
      end
      FMT_GRAYA: begin
        o.out_a = luma; o.out_b = alpha; o.out_count = 3'd2;
      end
      default: begin
        o.out_a = r; o.out_b = g; o.out_c = b; o.out_count = 3'd3;
      end
    endcase
    // narrowing keeps the low byte
    keep = dst_wide ? 16'hffff : 16'h00ff;
    o.out_a &= keep;
    o.out_b &= keep;
    o.out_c &= keep;
    o.out_d &= keep;
    return o;
  endfunction

  always @(posedge clk) begin
    out_pix_t want;
    if (!rst_n) begin
      src_code <= FMT_RGB;
      dst_code <= FMT_RGB;
      src_wide <= 1'b0;
      dst_wide <= 1'b0;
      leftover_checked <= 1'b0;
      pixel_q.delete();
      n_results <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_FMT:  src_code <= cfg_data;
          REG_DST_FMT:  dst_code <= cfg_data;
          REG_SRC_WIDE: src_wide <= cfg_data[0];
          REG_DST_WIDE: dst_wide <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy)
        pixel_q.push_back(predict_pixel(in_pix));
      if (out_valid) begin
        n_results <= n_results + 1;
        if (pixel_q.size() == 0) begin
          report_error($sformatf("result %h with nothing pending", out_pix));
        end else begin
          want = pixel_q.pop_front();
          compare_comp("out_a", out_pix.out_a, want.out_a);
          compare_comp("out_b", out_pix.out_b, want.out_b);
          compare_comp("out_c", out_pix.out_c, want.out_c);
          compare_comp("out_d", out_pix.out_d, want.out_d);
          compare_comp("out_count", 16'(out_pix.out_count), 16'(want.out_count));
        end
      end
      if (drained && !leftover_checked) begin
        leftover_checked <= 1'b1;
        if (pixel_q.size() != 0)
          report_error($sformatf("%0d expected pixels never arrived", pixel_q.size()));
      end
    end
  end

endmodule

/* dv/pixel_color_format_converter_tb.sv */
`timescale 1ns / 1ps
module pixel_color_format_converter_tb;
  import pcfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned MAX_GAP      = 12;
  localparam logic [2:0]  FMT_UNDEF_LO = 3'd6;
  localparam logic [2:0]  FMT_UNDEF_HI = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_pix_t    in_pix;
  logic       out_valid;
  out_pix_t   out_pix;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [2:0] cfg_data;
  logic       drained;
  int         n_results;
  int         n_fail;
  int         n_sent;
  int unsigned cycle_cnt = 0;

  pixel_color_format_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pix    (in_pix),
    .out_valid (out_valid),
    .out_pix   (out_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcfc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pix    (in_pix),
    .out_valid (out_valid),
    .out_pix   (out_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .drained   (drained),
    .n_results (n_results),
    .n_fail    (n_fail)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL pixel_color_format_converter");
      $finish;
    end
  end

  function automatic in_pix_t make_pix(input comp_t a, input comp_t b, input comp_t c,
                                       input comp_t d);
    in_pix_t p;
    p.comp_a = a;
    p.comp_b = b;
    p.comp_c = c;
    p.comp_d = d;
    return p;
  endfunction

  // lean toward the corners, keep most values fully random
  function automatic comp_t pick_comp();
    comp_t v;
    case ($urandom_range(0, 7))
      0: v = 16'h0000;
      1: v = 16'hffff;
      2: v = 16'h00ff;
      default: v = comp_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_fmt();
    logic [2:0] code;
    if ($urandom_range(0, 9) == 0)
      code = 3'($urandom_range(FMT_UNDEF_LO, FMT_UNDEF_HI));
    else
      code = 3'($urandom_range(FMT_RGB, FMT_GRAYA));
    return code;
  endfunction

  // hold start until the transfer completes
  task automatic send_pixel(input in_pix_t p, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_pix <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [2:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // drain every pending pixel, then rewrite all layout registers
  task automatic set_layout(input logic [2:0] sf, input logic [2:0] df, input logic sw,
                            input logic dw);
    start <= 1'b0;
    while (n_results != n_sent) @(posedge clk);
    write_reg(REG_SRC_FMT, sf);
    write_reg(REG_DST_FMT, df);
    write_reg(REG_SRC_WIDE, {2'b00, sw});
    write_reg(REG_DST_WIDE, {2'b00, dw});
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned rand_gap();
    return $urandom_range(0, MAX_GAP);
  endfunction

  initial begin
    int unsigned n_random;
    int unsigned n_phase;
    bit          burst;
    rst_n = 1'b0;
    start = 1'b0;
    in_pix = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SRC_FMT;
    cfg_data = '0;
    drained = 1'b0;
    n_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset layout: RGB to RGB, narrow, high bytes ignored
    send_pixel(make_pix(16'hffff, 16'hffff, 16'hffff, 16'hffff), rand_gap());
    send_pixel(make_pix(16'h0000, 16'h0000, 16'h0000, 16'h0000), rand_gap());

    // luma at full scale shows the truncation
    set_layout(FMT_RGB, FMT_GRAY, 1'b1, 1'b1);
    send_pixel(make_pix(16'hffff, 16'hffff, 16'hffff, 16'h0000), rand_gap());
    send_pixel(make_pix(16'h0000, 16'h0000, 16'h0000, 16'hffff), rand_gap());
    send_pixel(make_pix(16'h1234, 16'h8000, 16'h00ff, 16'h0000), rand_gap());

    set_layout(FMT_RGBA, FMT_BGRA, 1'b1, 1'b0);
    send_pixel(make_pix(16'h1234, 16'h5678, 16'h9abc, 16'hdef0), rand_gap());

    set_layout(FMT_RGBA, FMT_GRAYA, 1'b1, 1'b1);
    send_pixel(make_pix(16'hffff, 16'h0000, 16'h0000, 16'ha5a5), rand_gap());

    // no alpha in the source: alpha comes out zero
    set_layout(FMT_BGR, FMT_GRAYA, 1'b0, 1'b1);
    send_pixel(make_pix(16'h00ff, 16'h0000, 16'hff00, 16'hffff), rand_gap());

    set_layout(FMT_BGRA, FMT_RGBA, 1'b0, 1'b0);
    send_pixel(make_pix(16'hab11, 16'hcd22, 16'hef33, 16'h9944), rand_gap());

    set_layout(FMT_GRAY, FMT_RGBA, 1'b1, 1'b0);
    send_pixel(make_pix(16'habcd, 16'hffff, 16'hffff, 16'hffff), rand_gap());

    set_layout(FMT_GRAYA, FMT_BGRA, 1'b1, 1'b1);
    send_pixel(make_pix(16'hffff, 16'h8001, 16'hffff, 16'hffff), rand_gap());

    set_layout(FMT_GRAYA, FMT_RGB, 1'b0, 1'b1);
    send_pixel(make_pix(16'hff80, 16'h7f7f, 16'hffff, 16'hffff), rand_gap());

    // wide luma into a narrow destination keeps the low byte
    set_layout(FMT_RGB, FMT_GRAY, 1'b1, 1'b0);
    send_pixel(make_pix(16'hffff, 16'hffff, 16'hffff, 16'h0000), rand_gap());
    set_layout(FMT_GRAY, FMT_GRAY, 1'b1, 1'b0);
    send_pixel(make_pix(16'hfeab, 16'h0000, 16'h0000, 16'h0000), rand_gap());

    // undefined layout codes behave as RGB
    set_layout(FMT_UNDEF_HI, FMT_UNDEF_LO, 1'b1, 1'b1);
    send_pixel(make_pix(16'hffff, 16'h0000, 16'hffff, 16'hffff), rand_gap());
    set_layout(FMT_UNDEF_LO, FMT_GRAYA, 1'b0, 1'b0);
    send_pixel(make_pix(16'hffff, 16'hffff, 16'hffff, 16'hffff), rand_gap());

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      set_layout(pick_fmt(), pick_fmt(), 1'($urandom), 1'($urandom));
      burst = ($urandom_range(0, 3) == 0);
      n_phase = $urandom_range(4, 12);
      repeat (n_phase) begin
        send_pixel(make_pix(pick_comp(), pick_comp(), pick_comp(), pick_comp()),
                   burst ? 0 : rand_gap());
        n_random++;
      end
    end

    start <= 1'b0;
    while (n_results != n_sent) @(posedge clk);
    repeat (8) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    if (n_fail == 0)
      $display("PASS pixel_color_format_converter");
    else
      $display("FAIL pixel_color_format_converter");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/pcfc_pkg.sv
hdl/pcfc_unpack.sv
hdl/pcfc_pack.sv
hdl/pixel_color_format_converter.sv
dv/pcfc_checker.sv
dv/pixel_color_format_converter_tb.sv
